// ===== hw/rtl/pem_pkg.sv =====
// Shared types, constants and helpers for the pulse energy meter update core.
package pem_pkg;

	localparam int unsigned CountW = 24;
	localparam int unsigned MsW    = 16;
	localparam int unsigned CoefW  = 16;
	localparam int unsigned WordW  = 32;

	localparam logic [CountW-1:0] PulseClamp = 24'd4000000;
	localparam logic [9:0]        ScaleStep  = 10'd1000;
	localparam logic [14:0]       PowerMax   = 15'd32767;
	localparam logic [15:0]       HeldMax    = 16'd65535;

	localparam logic [CoefW-1:0] PowerCoefRst   = 16'd122;
	localparam logic [CoefW-1:0] VoltageCoefRst = 16'd62;
	localparam logic [CoefW-1:0] CurrentCoefRst = 16'd30;
	localparam logic [CoefW-1:0] PulsesPerWhRst = 16'd1000;

	typedef enum logic [2:0] {
		REG_POWER_COEF    = 3'd0,
		REG_VOLTAGE_COEF  = 3'd1,
		REG_CURRENT_COEF  = 3'd2,
		REG_PULSES_PER_WH = 3'd3,
		REG_SELECT_LEVEL  = 3'd4
	} cfg_reg_t;

	// sequencer: each working state waits for one pass of the shared divider
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PWR_Q,   // clamped power count * 1000 / ms
		ST_PWR_R,   // remainder * 1000 / ms
		ST_PWR_DIV, // power frequency / power_coef
		ST_ENERGY,  // residual pulses / pulse_per_whr
		ST_AUX_Q,
		ST_AUX_R,
		ST_AUX_DIV, // aux frequency / current or voltage coef
		ST_OUT
	} seq_state_t;

	// x * 1000 modulo 2^32
	function automatic logic [WordW-1:0] mul_scale(input logic [WordW-1:0] x);
		logic [WordW+9:0] p;
		p = {10'd0, x} * {{WordW{1'b0}}, ScaleStep};
		return p[WordW-1:0];
	endfunction

	// clamp a raw count and scale it; the result stays below 2^32
	function automatic logic [WordW-1:0] scaled_count(input logic [CountW-1:0] c);
		logic [CountW-1:0] cc;
		cc = (c > PulseClamp) ? PulseClamp : c;
		return mul_scale({{(WordW-CountW){1'b0}}, cc});
	endfunction

endpackage

// ===== hw/rtl/pulse_energy_meter_update_core.sv =====
// Pulse energy meter update: per-window frequency, power, voltage/current and energy.
// Each window transfer runs seven 32-bit by 16-bit divisions in sequence on one shared
// restoring divider that retires one quotient bit per cycle. The block accepts no new
// window until the result has been loaded into the output register. A result may wait in
// that register while the next window is accepted and worked on.
module pulse_energy_meter_update_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// power_pulses[23:0], aux_pulses[47:24], window_ms[63:48]
	input  logic [63:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// power_deca[14:0], volt_deci[30:15], amps_milli[46:31], whr_count[78:47],
	// energy_pulse_total[110:79], updated_current[111], select_level[112], zeros above
	output logic [119:0] m_axis_tdata
);

	// configuration
	logic [15:0] power_coef_q, voltage_coef_q, current_coef_q, pulse_per_whr_q;
	logic        sel_cur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_coef_q    <= pem_pkg::PowerCoefRst;
			voltage_coef_q  <= pem_pkg::VoltageCoefRst;
			current_coef_q  <= pem_pkg::CurrentCoefRst;
			pulse_per_whr_q <= pem_pkg::PulsesPerWhRst;
			sel_cur_q       <= 1'b0;
		end else if (cfg_we) begin
			case (pem_pkg::cfg_reg_t'(cfg_addr))
				pem_pkg::REG_POWER_COEF:    power_coef_q    <= cfg_wdata;
				pem_pkg::REG_VOLTAGE_COEF:  voltage_coef_q  <= cfg_wdata;
				pem_pkg::REG_CURRENT_COEF:  current_coef_q  <= cfg_wdata;
				pem_pkg::REG_PULSES_PER_WH: pulse_per_whr_q <= cfg_wdata;
				pem_pkg::REG_SELECT_LEVEL:  sel_cur_q       <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// shared restoring divider
	logic [31:0] dq_q;
	logic [15:0] dr_q;
	logic [15:0] dd_q;
	logic [4:0]  dcnt_q;
	logic        dbusy_q, ddone_q;
	logic        div_start;
	logic [31:0] div_num;
	logic [15:0] div_den;
	logic [16:0] trial;
	logic        trial_ge;
	logic [16:0] trial_diff;

	assign trial      = {dr_q, dq_q[31]};
	assign trial_ge   = trial >= {1'b0, dd_q};
	assign trial_diff = trial - {1'b0, dd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
			dcnt_q  <= '0;
		end else begin
			ddone_q <= 1'b0;
			if (div_start) begin
				dbusy_q <= 1'b1;
				dcnt_q  <= '0;
			end else if (dbusy_q) begin
				dcnt_q <= dcnt_q + 5'd1;
				if (dcnt_q == 5'd31) begin
					dbusy_q <= 1'b0;
					ddone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			dq_q <= div_num;
			dr_q <= '0;
			dd_q <= div_den;
		end else if (dbusy_q) begin
			dq_q <= {dq_q[30:0], trial_ge};
			dr_q <= trial_ge ? trial_diff[15:0] : trial[15:0];
		end
	end

	// window operands and working registers
	pem_pkg::seq_state_t state_q, state_d;
	logic [23:0] pp_q, ap_q;
	logic [15:0] ms_q;
	logic [31:0] acc_q;
	logic [14:0] power_q;
	logic [31:0] freq;
	logic        hs_in;

	logic        meas_cur_q;
	logic [31:0] residual_q, wh_q, total_q;
	logic [15:0] held_v_q, held_c_q;

	assign s_axis_tready = (state_q == pem_pkg::ST_IDLE);
	assign hs_in         = s_axis_tvalid && s_axis_tready;
	// q*1000 + (r*1000)/ms, zero for an empty window
	assign freq          = (ms_q == '0) ? '0 : acc_q + dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pem_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			pem_pkg::ST_IDLE: begin
				if (hs_in) begin
					div_start = 1'b1;
					div_num   = pem_pkg::scaled_count(s_axis_tdata[23:0]);
					div_den   = s_axis_tdata[63:48];
					state_d   = pem_pkg::ST_PWR_Q;
				end
			end
			pem_pkg::ST_PWR_Q, pem_pkg::ST_AUX_Q: begin
				if (ddone_q) begin
					div_start = 1'b1;
					div_num   = pem_pkg::mul_scale({16'd0, dr_q});
					div_den   = ms_q;
					state_d   = (state_q == pem_pkg::ST_PWR_Q) ? pem_pkg::ST_PWR_R
					                                           : pem_pkg::ST_AUX_R;
				end
			end
			pem_pkg::ST_PWR_R: begin
				if (ddone_q) begin
					div_start = 1'b1;
					div_num   = freq;
					div_den   = power_coef_q;
					state_d   = pem_pkg::ST_PWR_DIV;
				end
			end
			pem_pkg::ST_PWR_DIV: begin
				if (ddone_q) begin
					div_start = 1'b1;
					div_num   = residual_q + {8'd0, pp_q};
					div_den   = pulse_per_whr_q;
					state_d   = pem_pkg::ST_ENERGY;
				end
			end
			pem_pkg::ST_ENERGY: begin
				if (ddone_q) begin
					div_start = 1'b1;
					div_num   = pem_pkg::scaled_count(ap_q);
					div_den   = ms_q;
					state_d   = pem_pkg::ST_AUX_Q;
				end
			end
			pem_pkg::ST_AUX_R: begin
				if (ddone_q) begin
					div_start = 1'b1;
					div_num   = freq;
					div_den   = meas_cur_q ? current_coef_q : voltage_coef_q;
					state_d   = pem_pkg::ST_AUX_DIV;
				end
			end
			pem_pkg::ST_AUX_DIV: begin
				if (ddone_q) state_d = pem_pkg::ST_OUT;
			end
			pem_pkg::ST_OUT: begin
				if (!m_axis_tvalid || m_axis_tready) state_d = pem_pkg::ST_IDLE;
			end
			default: state_d = pem_pkg::ST_IDLE;
		endcase
	end

	// payload captured per window
	always_ff @(posedge clk) begin
		if (hs_in) begin
			pp_q <= s_axis_tdata[23:0];
			ap_q <= s_axis_tdata[47:24];
			ms_q <= s_axis_tdata[63:48];
		end
		if (ddone_q && (state_q == pem_pkg::ST_PWR_Q || state_q == pem_pkg::ST_AUX_Q))
			acc_q <= pem_pkg::mul_scale(dq_q);
		if (ddone_q && state_q == pem_pkg::ST_PWR_DIV)
			power_q <= (dq_q > {17'd0, pem_pkg::PowerMax}) ? pem_pkg::PowerMax : dq_q[14:0];
	end

	// meter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_cur_q <= 1'b1;
			residual_q <= '0;
			wh_q       <= '0;
			total_q    <= '0;
			held_v_q   <= '0;
			held_c_q   <= '0;
		end else if (ddone_q) begin
			case (state_q)
				pem_pkg::ST_PWR_DIV: begin
					total_q    <= total_q + {8'd0, pp_q};
					residual_q <= residual_q + {8'd0, pp_q};
				end
				pem_pkg::ST_ENERGY: begin
					// no conversion while the pulses-per-watt-hour coef is zero
					if (pulse_per_whr_q != '0) begin
						wh_q       <= wh_q + dq_q;
						residual_q <= {16'd0, dr_q};
					end
				end
				pem_pkg::ST_AUX_DIV: begin
					if (meas_cur_q)
						held_c_q <= (dq_q > {16'd0, pem_pkg::HeldMax}) ? pem_pkg::HeldMax
						                                               : dq_q[15:0];
					else
						held_v_q <= (dq_q > {16'd0, pem_pkg::HeldMax}) ? pem_pkg::HeldMax
						                                               : dq_q[15:0];
					meas_cur_q <= ~meas_cur_q;
				end
				default: ;
			endcase
		end
	end

	// output register
	logic        out_load;
	logic        m_valid_q;
	logic [119:0] m_data_q;

	assign out_load = (state_q == pem_pkg::ST_OUT) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)            m_valid_q <= 1'b0;
		else if (out_load)      m_valid_q <= 1'b1;
		else if (m_axis_tready) m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			m_data_q <= {7'd0,
			             (meas_cur_q ? sel_cur_q : ~sel_cur_q),
			             ~meas_cur_q,
			             total_q,
			             wh_q,
			             held_c_q,
			             held_v_q,
			             power_q};
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
	a_start_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !dbusy_q)
		else $error("divider restarted while busy");
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (!dbusy_q && !ddone_q))
		else $error("input ready while divider active");
	a_one_window: assert property (@(posedge clk) disable iff (!arst_n)
		hs_in |=> (!s_axis_tready && dbusy_q))
		else $error("window transfer did not launch the divider");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == pem_pkg::ST_OUT))
		else $error("result appeared outside the output step");
`endif

endmodule

// ===== verif/pem_window_checker.sv =====
// Checker for the pulse energy meter core: predicts each window's reading and compares.
module pem_window_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	// power_pulses[23:0], aux_pulses[47:24], window_ms[63:48]
	input  logic [63:0]  s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// power_deca[14:0], volt_deci[30:15], amps_milli[46:31], whr_count[78:47],
	// energy_pulse_total[110:79], updated_current[111], select_level[112], zeros above
	input  logic [119:0] m_axis_tdata,
	output int           fail_count,
	output int           pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [14:0] power_deca;
		logic [15:0] volt_deci;
		logic [15:0] amps_milli;
		logic [31:0] whr_count;
		logic [31:0] energy_pulse_total;
		logic        updated_current;
		logic        select_level;
	} meter_reading_t;

	meter_reading_t due_readings[$];

	// register copies
	logic [15:0] pwr_coef, volt_coef, cur_coef, pulses_wh;
	logic        sel_cur;

	// meter state
	logic        meas_cur;
	logic [31:0] residual, wh_total, pulse_sum;
	logic [15:0] held_volt, held_cur;

	// clamped count over the window, in mHz, 32-bit wrapping as the two-step scaling does
	function automatic logic [31:0] window_mhz(input logic [23:0] cnt, input logic [15:0] ms);
		logic [31:0] c, k, q, r, den;
		if (ms == 16'd0)
			return 32'd0;
		den = {16'd0, ms};
		c = (cnt > pem_pkg::PulseClamp) ? {8'd0, pem_pkg::PulseClamp} : {8'd0, cnt};
		k = c * 32'd1000;
		q = k / den;
		r = k % den;
		return q * 32'd1000 + (r * 32'd1000) / den;
	endfunction

	// zero divisor counts as all ones, so the output pins at its ceiling
	function automatic logic [31:0] sat_quotient(input logic [31:0] num, input logic [15:0] den,
			input logic [31:0] ceiling);
		logic [31:0] v;
		v = (den == 16'd0) ? 32'hFFFF_FFFF : num / {16'd0, den};
		return (v > ceiling) ? ceiling : v;
	endfunction

	function automatic meter_reading_t predict_reading(input logic [23:0] pp,
			input logic [23:0] ap, input logic [15:0] ms);
		meter_reading_t rd;
		logic [31:0] v;
		v = sat_quotient(window_mhz(pp, ms), pwr_coef, {17'd0, pem_pkg::PowerMax});
		rd.power_deca = v[14:0];
		pulse_sum = pulse_sum + {8'd0, pp};
		residual = residual + {8'd0, pp};
		if (pulses_wh != 16'd0) begin
			wh_total = wh_total + residual / {16'd0, pulses_wh};
			residual = residual % {16'd0, pulses_wh};
		end
		if (meas_cur) begin
			v = sat_quotient(window_mhz(ap, ms), cur_coef, {16'd0, pem_pkg::HeldMax});
			held_cur = v[15:0];
		end else begin
			v = sat_quotient(window_mhz(ap, ms), volt_coef, {16'd0, pem_pkg::HeldMax});
			held_volt = v[15:0];
		end
		rd.updated_current = meas_cur;
		meas_cur = ~meas_cur;
		rd.select_level = meas_cur ? sel_cur : ~sel_cur;
		rd.volt_deci = held_volt;
		rd.amps_milli = held_cur;
		rd.whr_count = wh_total;
		rd.energy_pulse_total = pulse_sum;
		return rd;
	endfunction

	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		meter_reading_t rd;
		if (!arst_n) begin
			pwr_coef = pem_pkg::PowerCoefRst;
			volt_coef = pem_pkg::VoltageCoefRst;
			cur_coef = pem_pkg::CurrentCoefRst;
			pulses_wh = pem_pkg::PulsesPerWhRst;
			sel_cur = 1'b0;
			meas_cur = 1'b1;
			residual = '0;
			wh_total = '0;
			pulse_sum = '0;
			held_volt = '0;
			held_cur = '0;
			due_readings.delete();
			pending_count = 0;
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (pem_pkg::cfg_reg_t'(cfg_addr))
					pem_pkg::REG_POWER_COEF:    pwr_coef = cfg_wdata;
					pem_pkg::REG_VOLTAGE_COEF:  volt_coef = cfg_wdata;
					pem_pkg::REG_CURRENT_COEF:  cur_coef = cfg_wdata;
					pem_pkg::REG_PULSES_PER_WH: pulses_wh = cfg_wdata;
					pem_pkg::REG_SELECT_LEVEL:  sel_cur = cfg_wdata[0];
					default: ;
				endcase
			end
			// result side first: a result can never belong to the window taken this same edge
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_readings.size() == 0) begin
					fail_count++;
					$display("%0t ns: result transfer with nothing pending, expected none, actual %h",
						$time, m_axis_tdata);
				end else begin
					rd = due_readings.pop_front();
					check_field("power_deca", {17'd0, rd.power_deca},
						{17'd0, m_axis_tdata[14:0]});
					check_field("volt_deci", {16'd0, rd.volt_deci},
						{16'd0, m_axis_tdata[30:15]});
					check_field("amps_milli", {16'd0, rd.amps_milli},
						{16'd0, m_axis_tdata[46:31]});
					check_field("whr_count", rd.whr_count, m_axis_tdata[78:47]);
					check_field("energy_pulse_total", rd.energy_pulse_total, m_axis_tdata[110:79]);
					check_field("updated_current", {31'd0, rd.updated_current},
						{31'd0, m_axis_tdata[111]});
					check_field("select_level", {31'd0, rd.select_level}, {31'd0, m_axis_tdata[112]});
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				due_readings.push_back(predict_reading(s_axis_tdata[23:0], s_axis_tdata[47:24],
					s_axis_tdata[63:48]));
			pending_count = due_readings.size();
		end
	end

endmodule

// ===== verif/tb_pulse_energy_meter_update_core.sv =====
// Testbench top for the pulse energy meter core: window stimulus, flow control and verdict.
module tb_pulse_energy_meter_update_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit    = 2_000_000;
	localparam int unsigned RandPhases    = 9;
	localparam int unsigned ItemsPerPhase = 82;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_addr = '0;
	logic [15:0]  cfg_wdata = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// power_pulses[23:0], aux_pulses[47:24], window_ms[63:48]
	logic [63:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// power_deca[14:0], volt_deci[30:15], amps_milli[46:31], whr_count[78:47],
	// energy_pulse_total[110:79], updated_current[111], select_level[112], zeros above
	logic [119:0] m_axis_tdata;

	int          src_idle_pct = 0;
	int          sink_stall_pct = 0;
	int          fail_count;
	int          pending_count;
	int unsigned cycles = 0;

	pulse_energy_meter_update_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	pem_window_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(input pem_pkg::cfg_reg_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(input logic [15:0] pc, input logic [15:0] vc, input logic [15:0] cc,
			input logic [15:0] ppw, input logic slc);
		write_reg(pem_pkg::REG_POWER_COEF, pc);
		write_reg(pem_pkg::REG_VOLTAGE_COEF, vc);
		write_reg(pem_pkg::REG_CURRENT_COEF, cc);
		write_reg(pem_pkg::REG_PULSES_PER_WH, ppw);
		write_reg(pem_pkg::REG_SELECT_LEVEL, {15'd0, slc});
	endtask

	// one window transfer; returns right after the accepting edge
	task automatic send_window(input logic [23:0] pp, input logic [23:0] ap,
			input logic [15:0] ms);
		@(negedge clk);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {ms, ap, pp};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// hold the sender off until every pending reading has come out
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (pending_count == 0);
	endtask

	function automatic logic [23:0] pick_count();
		case ($urandom_range(5, 0))
			0: return 24'd0;
			1: return 24'd1;
			2: return pem_pkg::PulseClamp;
			3: return pem_pkg::PulseClamp + 24'd1;
			4: return 24'hFF_FFFF;
			default: return 24'($urandom_range(24'hFF_FFFF, 0));
		endcase
	endfunction

	function automatic logic [15:0] pick_coef();
		case ($urandom_range(15, 0))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			default: return 16'($urandom_range(16'hFFFF, 1));
		endcase
	endfunction

	initial begin
		logic [23:0] pp, ap;
		logic [15:0] ms;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// reset coefficients; zero window, clamp edges, wrap of the scaled quotient
		send_window(24'd0, 24'd0, 16'd0);
		send_window(24'hFF_FFFF, 24'hFF_FFFF, 16'd0);
		send_window(24'd0, 24'd0, 16'd1);
		send_window(pem_pkg::PulseClamp, pem_pkg::PulseClamp, 16'd1);
		send_window(pem_pkg::PulseClamp + 24'd1, 24'hFF_FFFF, 16'd1);
		send_window(24'hFF_FFFF, pem_pkg::PulseClamp + 24'd1, 16'hFFFF);
		send_window(24'd1000, 24'd250, 16'd1000);
		send_window(24'd2, 24'd3, 16'd2);
		send_window(24'd999, 24'd12345, 16'd7);
		send_window(24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF);
		drain();

		write_all(16'd1, 16'd1, 16'd1, 16'd1, 1'b1);
		send_window(pem_pkg::PulseClamp, 24'd1, 16'd3);
		send_window(24'd5, pem_pkg::PulseClamp, 16'd1000);
		send_window(24'd123456, 24'd654321, 16'd999);
		drain();

		// zero coefficients saturate; a zero pulse-per-watt-hour coef parks pulses
		write_all(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
		send_window(24'd100, 24'd100, 16'd10);
		send_window(pem_pkg::PulseClamp, pem_pkg::PulseClamp, 16'd1);
		send_window(24'd1000, 24'd1000, 16'd0);
		send_window(24'd777, 24'd0, 16'hFFFF);
		drain();

		// nonzero pulse-per-watt-hour coef again: parked residual converts on the next window
		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_window(24'd65534, 24'd65534, 16'd500);
		send_window(24'hFF_FFFF, 24'hFF_FFFF, 16'd1);
		send_window(pem_pkg::PulseClamp, pem_pkg::PulseClamp, 16'hFFFF);
		drain();

		for (int ph = 0; ph < RandPhases; ph++) begin
			case (ph % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
				default: begin src_idle_pct = 23; sink_stall_pct = 23; end
			endcase
			write_all(pick_coef(), pick_coef(), pick_coef(), pick_coef(), 1'($urandom_range(1, 0)));
			for (int i = 0; i < ItemsPerPhase; i++) begin
				case ($urandom_range(9, 0))
					0: begin
						pp = 24'($urandom);
						ap = 24'($urandom);
						ms = 16'($urandom);
					end
					1: begin
						pp = pick_count();
						ap = pick_count();
						case ($urandom_range(3, 0))
							0: ms = 16'd0;
							1: ms = 16'd1;
							2: ms = 16'hFFFF;
							default: ms = 16'($urandom_range(16'hFFFF, 0));
						endcase
					end
					default: begin
						// plausible meter windows: tens of ms to seconds, sensible pulse rates
						ms = 16'($urandom_range(4000, 50));
						pp = 24'($urandom_range(5 * int'(ms), 0));
						ap = 24'($urandom_range(3 * int'(ms), 0));
					end
				endcase
				send_window(pp, ap, ms);
			end
			drain();
		end

		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/pem_pkg.sv
hw/rtl/pulse_energy_meter_update_core.sv
verif/pem_window_checker.sv
verif/tb_pulse_energy_meter_update_core.sv
